// ===== rtl/stepper_coil_sequencer_assert.svh =====
// assertion macros for the stepper coil sequencer
`ifndef STEPPER_COIL_SEQUENCER_ASSERT_SVH
`define STEPPER_COIL_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define SCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/scs_pkg.sv =====
`default_nettype none

package scs_pkg;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned ANGLE_W  = 16;
  localparam int unsigned COIL_W   = 4;
  localparam int unsigned TICKS_W  = 24;
  localparam int unsigned SEQ_W    = 17;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned IN_DW    = 24;
  localparam int unsigned OUT_DW   = 8;

  localparam logic [TICKS_W-1:0] TICKS_RESET = 24'd10;

  // floor(angle * 2048 / 1440) = (angle * SEQ_MULT) >> SEQ_SHIFT, exact for 16-bit angles
  localparam int unsigned PROD_W    = 47;
  localparam logic [30:0] SEQ_MULT  = 31'd1527099484;
  localparam int unsigned SEQ_SHIFT = 30;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_START   = 2'd1,
    FUNC_RELEASE = 2'd2,
    FUNC_NOP     = 2'd3
  } func_e;

  localparam logic [COIL_W-1:0] FULL_TAB [4] = '{4'h1, 4'h2, 4'h4, 4'h8};
  localparam logic [COIL_W-1:0] HALF_TAB [8] =
    '{4'h9, 4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8};

  function automatic logic [COIL_W-1:0] pattern_at(
    input logic             half_mode,
    input logic             reverse,
    input logic [IDX_W-1:0] pos
  );
    logic [IDX_W-1:0] last;
    logic [IDX_W-1:0] p;
    last = half_mode ? 3'd7 : 3'd3;
    p    = pos & last;
    if (reverse) begin
      p = last - p;
    end
    return half_mode ? HALF_TAB[p] : FULL_TAB[p[1:0]];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/stepper_coil_sequencer.sv =====
// Stepper coil sequencer: drives the blue, pink, yellow and orange coils.
// Slave stream: one word per command. tuser holds func (tick, start, release,
// no-op); tdata holds move_angle, turn_direction and step_mode. A start plays
// floor(angle*2048/1440) runs of the full-step (4) or half-step (8) pattern
// table, each pattern held for ticks_per_pattern tick words.
// Master stream: exactly one result word per command word, carrying the coil
// levels after the command and the moving, move_done and start_rejected flags.
// Config channel: cfg_data_i sets ticks_per_pattern (reset value 10, zero acts
// as one); write only while no command is in flight. cfg_ready_o is always high.
// A command word is taken into the input register; its result word is then
// written to the result register. Throughput: one word per cycle while the
// receiver is ready; the state update between the two is combinational.
// When the receiver stalls the result register holds and the input register
// still takes one more word; tready then falls until the result drains.
// Reset: coils low, idle, all counters clear, both registers empty.
`default_nettype none

module stepper_coil_sequencer (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        s_axis_tvalid,
  output logic                       s_axis_tready,
  // move_angle [15:0], turn_direction [16], step_mode [17], zero [23:18]
  input  wire  [scs_pkg::IN_DW-1:0]  s_axis_tdata,
  // func [1:0]
  input  wire  [scs_pkg::FUNC_W-1:0] s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire                        m_axis_tready,
  // coil_drive [3:0], moving [4], move_done [5], start_rejected [6], zero [7]
  output logic [scs_pkg::OUT_DW-1:0] m_axis_tdata,
  input  wire                        cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire  [scs_pkg::TICKS_W-1:0] cfg_data_i
);
  import scs_pkg::*;

  logic                 in_valid_q, in_valid_d;
  func_e                in_func_q;
  logic [ANGLE_W-1:0]   in_angle_q;
  logic                 in_dir_q, in_mode_q;
  logic                 out_valid_q, out_valid_d;
  logic [OUT_DW-1:0]    out_data_q, out_data_d;

  logic [TICKS_W-1:0]   ticks_q;
  logic [COIL_W-1:0]    coil_q, coil_d;
  logic                 busy_q, busy_d;
  logic [SEQ_W-1:0]     seq_left_q, seq_left_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [TICKS_W-1:0]   hold_q, hold_d;
  logic                 dir_q, dir_d;
  logic                 mode_q, mode_d;

  logic                 in_fire, proc_fire;
  logic [PROD_W-1:0]    seq_prod;
  logic [SEQ_W-1:0]     seqs;
  logic [TICKS_W-1:0]   reload;
  logic [TICKS_W-1:0]   hold_dec;
  logic [SEQ_W-1:0]     seq_dec;
  logic [IDX_W:0]       idx_inc;
  logic                 last_in_seq;
  logic                 done, rejected;

  assign cfg_ready_o   = 1'b1;
  assign proc_fire     = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || proc_fire;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign seq_prod    = PROD_W'(in_angle_q) * PROD_W'(SEQ_MULT);
  assign seqs        = seq_prod[SEQ_SHIFT +: SEQ_W];
  assign reload      = (ticks_q == '0) ? TICKS_W'(1) : ticks_q;
  assign hold_dec    = (hold_q != '0) ? hold_q - TICKS_W'(1) : hold_q;
  assign seq_dec     = (seq_left_q != '0) ? seq_left_q - SEQ_W'(1) : seq_left_q;
  assign idx_inc     = {1'b0, idx_q} + (IDX_W+1)'(1);
  assign last_in_seq = idx_inc >= (mode_q ? (IDX_W+1)'(8) : (IDX_W+1)'(4));

  always_comb begin
    in_valid_d  = in_fire ? 1'b1 : (proc_fire ? 1'b0 : in_valid_q);
    out_valid_d = proc_fire ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);
    coil_d      = coil_q;
    busy_d      = busy_q;
    seq_left_d  = seq_left_q;
    idx_d       = idx_q;
    hold_d      = hold_q;
    dir_d       = dir_q;
    mode_d      = mode_q;
    done        = 1'b0;
    rejected    = 1'b0;
    if (proc_fire) begin
      unique case (in_func_q)
        FUNC_START: begin
          if (busy_q) begin
            rejected = 1'b1;
          end else begin
            dir_d  = in_dir_q;
            mode_d = in_mode_q;
            if (seqs != '0) begin
              seq_left_d = seqs;
              idx_d      = '0;
              coil_d     = pattern_at(in_mode_q, in_dir_q, '0);
              hold_d     = reload;
              busy_d     = 1'b1;
            end
          end
        end
        FUNC_RELEASE: begin
          coil_d     = '0;
          busy_d     = 1'b0;
          seq_left_d = '0;
          idx_d      = '0;
          hold_d     = '0;
        end
        FUNC_TICK: begin
          if (busy_q) begin
            hold_d = hold_dec;
            if (hold_dec == '0) begin
              if (last_in_seq) begin
                seq_left_d = seq_dec;
                idx_d      = '0;
              end else begin
                idx_d = idx_inc[IDX_W-1:0];
              end
              if (last_in_seq && (seq_dec == '0)) begin
                busy_d = 1'b0;
                done   = 1'b1;
              end else begin
                coil_d = pattern_at(mode_q, dir_q, idx_d);
                hold_d = reload;
              end
            end
          end
        end
        FUNC_NOP: begin
        end
      endcase
    end
    out_data_d = {1'b0, rejected, done, busy_d, coil_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ticks_q     <= TICKS_RESET;
      coil_q      <= '0;
      busy_q      <= 1'b0;
      seq_left_q  <= '0;
      idx_q       <= '0;
      hold_q      <= '0;
      dir_q       <= 1'b0;
      mode_q      <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        ticks_q <= cfg_data_i;
      end
      coil_q      <= coil_d;
      busy_q      <= busy_d;
      seq_left_q  <= seq_left_d;
      idx_q       <= idx_d;
      hold_q      <= hold_d;
      dir_q       <= dir_d;
      mode_q      <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_func_q  <= func_e'(s_axis_tuser);
      in_angle_q <= s_axis_tdata[ANGLE_W-1:0];
      in_dir_q   <= s_axis_tdata[ANGLE_W];
      in_mode_q  <= s_axis_tdata[ANGLE_W+1];
    end
    if (proc_fire) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/stepper_coil_sequencer_checker.sv =====
`default_nettype none

`include "stepper_coil_sequencer_assert.svh"

module stepper_coil_sequencer_props (
  input wire                         clk_i,
  input wire                         rst_ni,
  input wire                         s_axis_tready,
  input wire                         m_axis_tvalid,
  input wire                         m_axis_tready,
  input wire  [scs_pkg::OUT_DW-1:0]  m_axis_tdata
);
  import scs_pkg::*;

  `SCS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")
  `SCS_ASSERT_NOW(a_done_idle, m_axis_tvalid && m_axis_tdata[5], !m_axis_tdata[4], "move_done while still moving")
  `SCS_ASSERT_NOW(a_reject_busy, m_axis_tvalid && m_axis_tdata[6], m_axis_tdata[4] && !m_axis_tdata[5], "start rejected while idle")
  `SCS_ASSERT_NOW(a_coils_driven, m_axis_tvalid && m_axis_tdata[4], m_axis_tdata[COIL_W-1:0] != '0, "moving with all coils low")
  `SCS_ASSERT_NOW(a_in_stall, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled with no result held")

endmodule

bind stepper_coil_sequencer stepper_coil_sequencer_props u_props (.*);

`default_nettype wire

// ===== dv/stepper_coil_sequencer_checker.sv =====
`default_nettype none

module stepper_coil_sequencer_checker (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cmd_valid_i,
  input  wire                          cmd_ready_i,
  input  wire  [scs_pkg::IN_DW-1:0]    cmd_data_i,
  input  wire  [scs_pkg::FUNC_W-1:0]   cmd_func_i,
  input  wire                          res_valid_i,
  input  wire                          res_ready_i,
  input  wire  [scs_pkg::OUT_DW-1:0]   res_data_i,
  input  wire                          cfg_valid_i,
  input  wire                          cfg_ready_i,
  input  wire  [scs_pkg::TICKS_W-1:0]  cfg_data_i,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           words_o,
  output int                           moves_done_o,
  output int                           refused_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import scs_pkg::*;

  typedef struct packed {
    logic              refused;
    logic              done;
    logic              moving;
    logic [COIL_W-1:0] coils;
  } coil_word_t;

  localparam logic [COIL_W-1:0] FOUR_PATTERNS [4] = '{4'h1, 4'h2, 4'h4, 4'h8};
  localparam logic [COIL_W-1:0] EIGHT_PATTERNS [8] =
    '{4'h9, 4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8};

  // motor state as the block should hold it
  logic [TICKS_W-1:0] hold_setting;
  logic [COIL_W-1:0]  coils_q;
  logic               busy_q;
  logic [SEQ_W-1:0]   runs_left;
  logic [IDX_W-1:0]   phase_q;
  logic [TICKS_W-1:0] hold_left;
  logic               reverse_q;
  logic               half_q;

  coil_word_t predicted_coil_words [$];
  int fails;
  int words_seen;
  int moves_seen;
  int refused_seen;

  function automatic logic [TICKS_W-1:0] hold_reload();
    return (hold_setting == '0) ? TICKS_W'(1) : hold_setting;
  endfunction

  function automatic logic [COIL_W-1:0] coil_pattern(input logic [IDX_W-1:0] pos);
    int unsigned len;
    int unsigned p;
    len = half_q ? 8 : 4;
    p   = int'(pos) % len;
    if (reverse_q) begin
      p = len - 1 - p;
    end
    return half_q ? EIGHT_PATTERNS[p] : FOUR_PATTERNS[p];
  endfunction

  function automatic coil_word_t step_motor(input func_e f, input logic [ANGLE_W-1:0] ang,
                                            input logic dir, input logic hm);
    coil_word_t  w;
    int unsigned runs;
    int unsigned len;
    logic        ended;
    w     = '0;
    ended = 1'b0;
    case (f)
      FUNC_START: begin
        if (busy_q) begin
          w.refused = 1'b1;
        end else begin
          runs      = (int'(ang) * 2048) / 1440;
          reverse_q = dir;
          half_q    = hm;
          if (runs != 0) begin
            runs_left = SEQ_W'(runs);
            phase_q   = '0;
            coils_q   = coil_pattern('0);
            hold_left = hold_reload();
            busy_q    = 1'b1;
          end
        end
      end
      FUNC_RELEASE: begin
        coils_q   = '0;
        busy_q    = 1'b0;
        runs_left = '0;
        phase_q   = '0;
        hold_left = '0;
      end
      FUNC_TICK: begin
        if (busy_q) begin
          if (hold_left != '0) begin
            hold_left = hold_left - 1'b1;
          end
          if (hold_left == '0) begin
            len = half_q ? 8 : 4;
            if (int'(phase_q) + 1 >= len) begin
              if (runs_left != '0) begin
                runs_left = runs_left - 1'b1;
              end
              phase_q = '0;
              ended   = (runs_left == '0);
            end else begin
              phase_q = phase_q + 1'b1;
            end
            if (ended) begin
              busy_q = 1'b0;
              w.done = 1'b1;
            end else begin
              coils_q   = coil_pattern(phase_q);
              hold_left = hold_reload();
            end
          end
        end
      end
      default: begin
      end
    endcase
    w.coils  = coils_q;
    w.moving = busy_q;
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    coil_word_t want;
    coil_word_t got;
    if (!rst_ni) begin
      hold_setting = TICKS_RESET;
      coils_q      = '0;
      busy_q       = 1'b0;
      runs_left    = '0;
      phase_q      = '0;
      hold_left    = '0;
      reverse_q    = 1'b0;
      half_q       = 1'b0;
      predicted_coil_words.delete();
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        hold_setting = cfg_data_i;
      end
      if (cmd_valid_i && cmd_ready_i) begin
        predicted_coil_words.push_back(step_motor(func_e'(cmd_func_i), cmd_data_i[15:0],
                                                  cmd_data_i[16], cmd_data_i[17]));
      end
      if (res_valid_i && res_ready_i) begin
        got = res_data_i[6:0];
        if (predicted_coil_words.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("unexpected result word %h with nothing outstanding", res_data_i);
          end
        end else begin
          want = predicted_coil_words.pop_front();
          words_seen++;
          if (want.done) begin
            moves_seen++;
          end
          if (want.refused) begin
            refused_seen++;
          end
          if (got !== want) begin
            fails++;
            if (fails <= 10) begin
              $display("word %0d mismatch: coils %h/%h moving %b/%b done %b/%b refused %b/%b",
                       words_seen, want.coils, got.coils, want.moving, got.moving,
                       want.done, got.done, want.refused, got.refused);
            end
          end
        end
      end
      pending_o <= predicted_coil_words.size();
    end
  end

  assign fail_count_o = fails;
  assign words_o      = words_seen;
  assign moves_done_o = moves_seen;
  assign refused_o    = refused_seen;

endmodule

`default_nettype wire

// ===== dv/tb_stepper_coil_sequencer.sv =====
`default_nettype none

module tb_stepper_coil_sequencer;

  timeunit 1ns;
  timeprecision 1ps;

  import scs_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [IN_DW-1:0]    s_axis_tdata  = '0;
  logic [FUNC_W-1:0]   s_axis_tuser  = FUNC_NOP;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_DW-1:0]   m_axis_tdata;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [TICKS_W-1:0]  cfg_data_i    = '0;

  int fail_count;
  int pending;
  int words_checked;
  int moves_done;
  int starts_refused;

  int          cycle_count  = 0;
  int          words_sent   = 0;
  int unsigned hold_now     = 10;
  logic        tx_idle_on   = 1'b1;
  logic        rx_idle_on   = 1'b1;
  logic        long_hold_req = 1'b0;

  always #5 clk_i = ~clk_i;

  stepper_coil_sequencer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  stepper_coil_sequencer_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (s_axis_tvalid),
    .cmd_ready_i  (s_axis_tready),
    .cmd_data_i   (s_axis_tdata),
    .cmd_func_i   (s_axis_tuser),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_i   (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .words_o      (words_checked),
    .moves_done_o (moves_done),
    .refused_o    (starts_refused)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("[stepper_coil_sequencer] ERROR");
      $finish;
    end
  end

  // receiver: random stall bursts, plus one long hold so the block backs up
  initial begin : result_sink
    int gap;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (80) @(posedge clk_i);
        m_axis_tready <= 1'b1;
        wait (!long_hold_req);
      end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
        gap = $urandom_range(1, 7);
        m_axis_tready <= 1'b0;
        repeat (gap - 1) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_word(input func_e f, input logic [ANGLE_W-1:0] ang,
                           input logic dir, input logic hm);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= {6'd0, hm, dir, ang};
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
  endtask

  task automatic send_noise();
    send_word(func_e'($urandom_range(0, 3)), 16'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_hold_ticks(input logic [TICKS_W-1:0] v);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    hold_now = (v == '0) ? 1 : v;
  endtask

  // optional release, start, then mostly ticks with the odd extra start, no-op or early release
  task automatic run_move();
    logic [ANGLE_W-1:0] ang;
    logic               dir;
    logic               hm;
    int unsigned        span;
    int unsigned        ticks_sent;
    int unsigned        cut_at;
    int unsigned        pick;
    ang  = 16'($urandom_range(1, 4));
    dir  = 1'($urandom);
    hm   = 1'($urandom);
    span = ((32'(ang) * 2048) / 1440) * (hm ? 8 : 4) * hold_now;
    if (span > 40) begin
      span = 40;
    end
    span   = span + $urandom_range(0, 3);
    cut_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, span) : span + 1;
    if ($urandom_range(0, 3) != 0) begin
      send_word(FUNC_RELEASE, 16'($urandom), 1'($urandom), 1'($urandom));
    end
    send_word(FUNC_START, ang, dir, hm);
    ticks_sent = 0;
    while (ticks_sent < span && ticks_sent != cut_at) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        send_word(FUNC_START,
                  ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4)),
                  1'($urandom), 1'($urandom));
      end else if (pick == 1) begin
        send_word(FUNC_NOP, 16'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        send_word(FUNC_TICK, 16'($urandom), 1'($urandom), 1'($urandom));
        ticks_sent++;
      end
    end
    if (ticks_sent == cut_at) begin
      send_word(FUNC_RELEASE, 16'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  // leave a move running so the new setting lands mid-hold
  task automatic begin_phase(input logic [TICKS_W-1:0] v);
    send_word(FUNC_RELEASE, 16'($urandom), 1'($urandom), 1'($urandom));
    send_word(FUNC_START, 16'd2, 1'($urandom), 1'($urandom));
    repeat (2) send_word(FUNC_TICK, 16'($urandom), 1'($urandom), 1'($urandom));
    write_hold_ticks(v);
  endtask

  initial begin : stimulus
    logic [TICKS_W-1:0] hold_plan [7];
    int                 budget [7];
    int                 stop_at;
    logic               last_phase;
    hold_plan = '{24'd1, 24'd2, 24'd0, 24'hFFFFFF, 24'd3, 24'd1, 24'd1};
    budget    = '{300, 300, 300, 60, 300, 300, 320};
    hold_plan[5] = TICKS_W'($urandom_range(1, 4));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle tick, no-op, zero-length start, idle release
    send_word(FUNC_TICK, 16'hFFFF, 1'b1, 1'b1);
    send_word(FUNC_NOP, 16'h0000, 1'b0, 1'b0);
    send_word(FUNC_START, 16'd0, 1'b1, 1'b1);
    send_word(FUNC_RELEASE, 16'hFFFF, 1'b1, 1'b1);
    write_hold_ticks(24'd1);
    // one full-step run clockwise, refused start on top
    send_word(FUNC_START, 16'd1, 1'b0, 1'b0);
    send_word(FUNC_START, 16'hFFFF, 1'b1, 1'b1);
    repeat (4) send_word(FUNC_TICK, 16'h0000, 1'b0, 1'b0);
    send_word(FUNC_TICK, 16'h0000, 1'b0, 1'b0);
    // one half-step run anticlockwise
    send_word(FUNC_START, 16'd1, 1'b1, 1'b1);
    repeat (8) send_word(FUNC_TICK, 16'hFFFF, 1'b1, 1'b1);
    // largest angle, aborted by release
    send_word(FUNC_START, 16'hFFFF, 1'b1, 1'b0);
    send_word(FUNC_TICK, 16'h0000, 1'b0, 1'b0);
    send_word(FUNC_NOP, 16'hFFFF, 1'b1, 1'b1);
    send_word(FUNC_RELEASE, 16'h0000, 1'b0, 1'b0);
    send_word(FUNC_TICK, 16'h0000, 1'b0, 1'b0);

    for (int p = 0; p < 7; p++) begin
      begin_phase(hold_plan[p]);
      last_phase = (p == 6);
      rx_idle_on    <= !last_phase && (p != 4);
      long_hold_req <= (p == 1);
      stop_at = words_sent + budget[p];
      while (words_sent < stop_at) begin
        tx_idle_on = !last_phase && ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 4) != 0) begin
          run_move();
        end else begin
          repeat ($urandom_range(1, 5)) send_noise();
        end
      end
    end

    drain_results();
    $display("checked %0d result words over 7 hold settings", words_checked);
    $display("%0d moves completed, %0d starts refused", moves_done, starts_refused);
    if (fail_count == 0) begin
      $display("[stepper_coil_sequencer] OK");
    end else begin
      $display("%0d mismatching words", fail_count);
      $display("[stepper_coil_sequencer] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
